// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: clocked on clock, quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pde_pkg.sv =====
// ----------------------------------------------------------------------------
// pde_pkg
// Shared types of the proper divisor enumerator: sequencer states and the
// selector between the small divisor list and the cofactor stack.
// ----------------------------------------------------------------------------
package pde_pkg;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_SEND
   } pde_state_type;

   // Which half of a divisor pair is read
   typedef enum logic {
      PH_SMALL,
      PH_COFACTOR
   } pde_phase_type;

endpackage

// ===== src/pde_req_if.sv =====
// ----------------------------------------------------------------------------
// pde_req_if
// Request channel: one number word per handshake.
// ----------------------------------------------------------------------------
interface pde_req_if #(
   parameter int unsigned NUMBER_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

// ===== src/pde_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pde_rsp_if
// Response channel: one divisor word per handshake, with last and empty flags.
// ----------------------------------------------------------------------------
interface pde_rsp_if #(
   parameter int unsigned NUMBER_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] divisor;
   logic                   last;
   logic                   empty_res;

   modport source (output valid, output divisor, output last, output empty_res,
                   input ready);
   modport sink   (input valid, input divisor, input last, input empty_res,
                   output ready);
endinterface

// ===== src/proper_divisor_enumerator_core.sv =====
// ----------------------------------------------------------------------------
// proper_divisor_enumerator_core
// Lists the proper divisors of one number in ascending order by trial
// division with a shared iterative divider and a divisor pair memory.
//
//   channel  dir  handshake          word
//   req      in   valid/ready        number
//   rsp      out  valid/ready        divisor, last, empty_res
//
// Each candidate i takes one run of the shared divider; the scan runs for
// candidates 1 .. floor(sqrt(n)) + 1 (or until PAIR_DEPTH pairs).
// Each result then takes a memory read (ST_FETCH), then a send (ST_SEND)
// that rsp stalls can hold. Numbers 0 and 1 skip the scan and give one
// empty result.
// req.ready is high only between numbers; reset is synchronous and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module proper_divisor_enumerator_core
   import pde_pkg::*;
#(
   parameter int unsigned NUMBER_BITS = 12,
   parameter int unsigned PAIR_DEPTH  = 32
) (
   input  logic      clock,
   input  logic      reset,
   pde_req_if.sink   req_chan,
   pde_rsp_if.source rsp_chan
);

   localparam int unsigned IDX_W = $clog2(PAIR_DEPTH);
   localparam int unsigned CNT_W = $clog2(PAIR_DEPTH + 1);

   pde_state_type          state_ff, state_in;
   pde_phase_type          phase_ff, phase_in;
   logic [NUMBER_BITS-1:0] number_ff, number_in;
   logic [NUMBER_BITS-1:0] cand_ff, cand_in;
   logic [CNT_W-1:0]       pairs_ff, pairs_in;
   logic                   square_ff, square_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   last_ff, last_in;
   logic                   empty_ff, empty_in;

   logic                   div_start;
   logic                   div_done;
   logic [NUMBER_BITS-1:0] div_quo;
   logic [NUMBER_BITS-1:0] div_rem;
   logic                   wr_en;
   logic                   rd_en;
   logic [NUMBER_BITS-1:0] rd_data;
   logic [CNT_W-1:0]       ctop;
   logic [IDX_W-1:0]       last_small_idx;

   // Cofactor stack top after dropping a repeated root
   assign ctop           = pairs_ff - CNT_W'(square_ff);
   assign last_small_idx = IDX_W'(pairs_ff - CNT_W'(1));

   pde_divider #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (number_in),
      .divisor   (cand_in),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   pde_pair_store #(
      .NUMBER_BITS (NUMBER_BITS),
      .PAIR_DEPTH  (PAIR_DEPTH)
   ) u_pair_store (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (pairs_ff[IDX_W-1:0]),
      .wr_small    (cand_ff),
      .wr_cofactor (div_quo),
      .rd_en       (rd_en),
      .rd_addr     (idx_ff),
      .rd_sel      (phase_ff),
      .rd_data     (rd_data)
   );

   // Sequence the scan and the emission
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      number_in = number_ff;
      cand_in   = cand_ff;
      pairs_in  = pairs_ff;
      square_in = square_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      empty_in  = empty_ff;
      div_start = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               number_in = req_chan.number;
               cand_in   = NUMBER_BITS'(1);
               pairs_in  = '0;
               square_in = 1'b0;
               idx_in    = '0;
               phase_in  = PH_SMALL;
               last_in   = 1'b0;
               empty_in  = (req_chan.number <= NUMBER_BITS'(1));
               if (req_chan.number <= NUMBER_BITS'(1)) begin
                  last_in  = 1'b1;
                  state_in = ST_SEND;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (cand_ff > div_quo) begin
                  // i*i exceeds n: scan done
                  idx_in   = '0;
                  phase_in = PH_SMALL;
                  state_in = ST_FETCH;
               end else begin
                  cand_in = cand_ff + NUMBER_BITS'(1);
                  if (div_rem == '0) begin
                     wr_en     = 1'b1;
                     pairs_in  = pairs_ff + CNT_W'(1);
                     square_in = (cand_ff == div_quo);
                  end
                  if (div_rem == '0 && pairs_ff == CNT_W'(PAIR_DEPTH - 1)) begin
                     // stack full: stop scanning
                     idx_in   = '0;
                     phase_in = PH_SMALL;
                     state_in = ST_FETCH;
                  end else begin
                     div_start = 1'b1;
                  end
               end
            end
         end
         ST_FETCH: begin
            rd_en = 1'b1;
            if (phase_ff == PH_SMALL) begin
               last_in = (idx_ff == last_small_idx) && (ctop <= CNT_W'(1));
            end else begin
               last_in = (idx_ff == IDX_W'(1));
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_chan.ready) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else if (phase_ff == PH_SMALL) begin
                  if (idx_ff == last_small_idx) begin
                     idx_in   = IDX_W'(ctop - CNT_W'(1));
                     phase_in = PH_COFACTOR;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
                  state_in = ST_FETCH;
               end else begin
                  idx_in   = idx_ff - IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state; clear control on reset
   always_ff @(posedge clock) begin
      number_ff <= number_in;
      cand_ff   <= cand_in;
      square_ff <= square_in;
      idx_ff    <= idx_in;
      phase_ff  <= phase_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         pairs_ff <= '0;
      end else begin
         state_ff <= state_in;
         pairs_ff <= pairs_in;
      end
   end

   // Drive the channels
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_SEND);
   assign rsp_chan.divisor   = empty_ff ? '0 : rd_data;
   assign rsp_chan.last      = last_ff;
   assign rsp_chan.empty_res = empty_ff;

`include "assert_macros.svh"

   `ASSERT_IMPL(a_idle_no_rsp, req_chan.ready, !rsp_chan.valid, "result pending while idle")
   `ASSERT_IMPL(a_empty_is_last, rsp_chan.valid && rsp_chan.empty_res, rsp_chan.last,
                "empty result not flagged last")
   `ASSERT_IMPL(a_done_in_divide, div_done, state_ff == ST_DIVIDE, "divider done outside scan")
   `ASSERT_ALWAYS(a_pairs_bound, pairs_ff <= CNT_W'(PAIR_DEPTH), "pair count overflow")

endmodule

// ===== src/pde_divider.sv =====
// ----------------------------------------------------------------------------
// pde_divider
// Restoring radix-2 divider: one quotient bit per cycle, then a one-cycle
// done pulse with quotient and remainder held.
// ----------------------------------------------------------------------------
module pde_divider
   import pde_pkg::*;
#(
   parameter int unsigned NUMBER_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUMBER_BITS-1:0] dividend,
   input  logic [NUMBER_BITS-1:0] divisor,
   output logic                   done,
   output logic [NUMBER_BITS-1:0] quotient,
   output logic [NUMBER_BITS-1:0] remainder
);

   localparam int unsigned CNT_W = $clog2(NUMBER_BITS + 1);

   logic [NUMBER_BITS-1:0] rem_ff, rem_in;
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [NUMBER_BITS-1:0] den_ff, den_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [NUMBER_BITS:0]   shifted;
   logic [NUMBER_BITS:0]   diff;

   // Shift in the next dividend bit and trial-subtract the divisor
   always_comb begin
      shifted = {rem_ff, quo_ff[NUMBER_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = CNT_W'(NUMBER_BITS);
      end else if (cnt_ff != '0) begin
         if (diff[NUMBER_BITS]) begin
            rem_in = shifted[NUMBER_BITS-1:0];
            quo_in = {quo_ff[NUMBER_BITS-2:0], 1'b0};
         end else begin
            rem_in = diff[NUMBER_BITS-1:0];
            quo_in = {quo_ff[NUMBER_BITS-2:0], 1'b1};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`include "assert_macros.svh"

   `ASSERT_IMPL(a_rem_below_den, done_ff, rem_ff < den_ff, "remainder not below divisor")
   `ASSERT_NEXT(a_start_runs, start, cnt_ff != '0, "divider idle after start")
   `ASSERT_IMPL(a_done_after_run, done_ff, $past(cnt_ff) == CNT_W'(1), "stray done pulse")

endmodule

// ===== src/pde_pair_store.sv =====
// ----------------------------------------------------------------------------
// pde_pair_store
// Divisor pair memory: small divisor list and cofactor stack written together
// at one address, one half read per cycle through a registered read port.
// ----------------------------------------------------------------------------
module pde_pair_store
   import pde_pkg::*;
#(
   parameter int unsigned NUMBER_BITS = 12,
   parameter int unsigned PAIR_DEPTH  = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(PAIR_DEPTH)-1:0] wr_addr,
   input  logic [NUMBER_BITS-1:0]        wr_small,
   input  logic [NUMBER_BITS-1:0]        wr_cofactor,
   input  logic                          rd_en,
   input  logic [$clog2(PAIR_DEPTH)-1:0] rd_addr,
   input  pde_phase_type                 rd_sel,
   output logic [NUMBER_BITS-1:0]        rd_data
);

   logic [NUMBER_BITS-1:0] small_mem [PAIR_DEPTH];
   logic [NUMBER_BITS-1:0] cof_mem   [PAIR_DEPTH];
   logic [NUMBER_BITS-1:0] rd_data_ff;

   // Write both halves of a pair
   always_ff @(posedge clock) begin
      if (wr_en) begin
         small_mem[wr_addr] <= wr_small;
         cof_mem[wr_addr]   <= wr_cofactor;
      end
   end

   // Read the selected half, hold until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_sel == PH_COFACTOR) begin
            rd_data_ff <= cof_mem[rd_addr];
         end else begin
            rd_data_ff <= small_mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
